// ----- rtl/mcobt_pkg.sv -----
// ----------------------------------------------------------------------------
// mcobt_pkg
// shared types and constants for the multi-channel off and blink timer
// ----------------------------------------------------------------------------
package mcobt_pkg;

    localparam int LIGHT_CHANNELS = 5;
    localparam int HORN_CHANNELS  = 2;
    localparam int TIMED_CH       = LIGHT_CHANNELS + HORN_CHANNELS;
    localparam int ALL_CH         = TIMED_CH + 1;
    // channel field is three bits wide, so at most eight channels are served
    localparam int NUM_CH         = (ALL_CH < 8) ? ALL_CH : 8;
    localparam int CH_W           = $clog2(NUM_CH);

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 3;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_ARM   = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    localparam logic [2:0] WR_SEL_LIGHT = 3'd0;
    localparam logic [2:0] WR_SEL_HORN  = 3'd1;

    // per-channel timer record kept in the channel memory
    typedef struct packed {
        logic [15:0] off_cnt;
        logic [9:0]  off_lim;
        logic        off_act;
        logic [12:0] blk_cnt;
        logic [7:0]  blk_lim;
        logic        blk_act;
    } mcobt_rec_t;

    // max(1, 60 * limit)
    function automatic logic [15:0] off_threshold(input logic [9:0] lim);
        logic [15:0] t;
        t = {lim, 6'b0} - {4'b0, lim, 2'b0};
        return (t == 16'd0) ? 16'd1 : t;
    endfunction

    // max(1, 30 * limit)
    function automatic logic [12:0] blink_threshold(input logic [7:0] lim);
        logic [12:0] t;
        t = {lim, 5'b0} - {4'b0, lim, 1'b0};
        return (t == 13'd0) ? 13'd1 : t;
    endfunction

endpackage

// ----- rtl/multi_channel_off_and_blink_timer_top.sv -----
// ----------------------------------------------------------------------------
// multi_channel_off_and_blink_timer_top
// eight-channel auto-off and blink timer for lights, horns and a fan
// ----------------------------------------------------------------------------
// Arm and write beats are taken in the idle state and produce no output. A tick
// beat walks the channel memory one channel per cycle unless the result side
// stalls it: the accept cycle issues the first read, then one read-modify-write
// step per channel (eight), then a flush step hands over the final message;
// s_tready stays low from the accept until the tick is back in idle. The flush
// step is spent even when the tick has nothing to report. Each tick reports at
// most one message per channel; a message waits in a one-entry holding slot
// until the next one appears or the tick ends, so the final beat can carry
// tlast. When m_tready is held low the channel walk pauses at a channel with a
// message to report once the holding slot and the output register are full.
// The channel state lives in a small synchronous memory with a registered read;
// per-entry valid bits, cleared by reset, make an unwritten entry read as zero.
module multi_channel_off_and_blink_timer_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration: fan_off_message
    input  logic                               cfg_wr_en,
    input  logic [7:0]                         cfg_wr_data,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // channel[2:0], off_minutes[12:3], off_enable[13], blink_halfperiods[21:14],
    // blink_enable[22], out_value[30:23], zero[31]
    input  logic [mcobt_pkg::S_TDATA_W-1:0]    s_tdata,
    // command[1:0]
    input  logic [mcobt_pkg::S_TUSER_W-1:0]    s_tuser,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // message[7:0]
    output logic [mcobt_pkg::M_TDATA_W-1:0]    m_tdata,
    // source_channel[2:0]
    output logic [mcobt_pkg::M_TUSER_W-1:0]    m_tuser,
    output logic                               m_tlast
);
    import mcobt_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROC  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    // input beat fields
    logic [1:0] in_cmd;
    logic [2:0] in_ch;
    logic [9:0] in_off_min;
    logic       in_off_en;
    logic [7:0] in_blk_half;
    logic       in_blk_en;
    logic [7:0] in_out_val;

    assign in_cmd      = s_tuser[1:0];
    assign in_ch       = s_tdata[2:0];
    assign in_off_min  = s_tdata[12:3];
    assign in_off_en   = s_tdata[13];
    assign in_blk_half = s_tdata[21:14];
    assign in_blk_en   = s_tdata[22];
    assign in_out_val  = s_tdata[30:23];

    // control and payload registers
    logic [1:0]      state_reg, state_next;
    logic [CH_W-1:0] ch_reg, ch_next;
    logic [7:0]      fan_msg_reg;
    logic [7:0]      light_bits_reg, light_bits_next;
    logic [7:0]      horn_bits_reg, horn_bits_next;

    // holding slot for the newest message of the tick
    logic       pend_valid_reg, pend_valid_next;
    logic [7:0] pend_msg_reg, pend_msg_next;
    logic [2:0] pend_ch_reg, pend_ch_next;

    // output register
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_msg_reg, m_msg_next;
    logic [2:0] m_ch_reg, m_ch_next;
    logic       m_last_reg, m_last_next;

    // channel memory
    mcobt_rec_t      mem [NUM_CH];
    logic [NUM_CH-1:0] ent_valid_reg;
    mcobt_rec_t      rd_data_reg;
    logic            rd_valid_reg;
    logic            rd_en;
    logic [CH_W-1:0] rd_addr;
    logic            wr_en;
    logic [CH_W-1:0] wr_addr;
    mcobt_rec_t      wr_data;

    // per-channel update
    mcobt_rec_t rec_cur, rec_new, arm_rec;
    logic        timed;
    logic        is_light;
    logic [2:0]  ch3;
    logic [7:0]  bit_mask;
    logic [15:0] off_inc;
    logic [12:0] blk_inc;
    logic        off_fire, blk_fire;
    logic        emit;
    logic [7:0]  emit_msg;
    logic [7:0]  byte_cur, byte_new;
    logic        out_free;
    logic        proceed;
    logic        accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // record as read, an unwritten entry reads as zero
    assign rec_cur = rd_valid_reg ? rd_data_reg : '0;

    always_comb begin
        ch3      = 3'(ch_reg);
        timed    = (int'(ch_reg) < TIMED_CH);
        is_light = (int'(ch_reg) < LIGHT_CHANNELS);
        // bit owned by this channel in its output byte
        if (is_light) begin
            bit_mask = 8'd1 << ch3;
            byte_cur = light_bits_reg;
        end else begin
            bit_mask = 8'd1 << 3'(ch3 - 3'(LIGHT_CHANNELS));
            byte_cur = horn_bits_reg;
        end

        rec_new  = rec_cur;
        byte_new = byte_cur;
        emit     = 1'b0;
        emit_msg = byte_cur;
        off_inc  = rec_cur.off_cnt + 16'd1;
        blk_inc  = rec_cur.blk_cnt + 13'd1;
        off_fire = rec_cur.off_act && (off_inc >= off_threshold(rec_cur.off_lim));
        blk_fire = 1'b0;

        if (rec_cur.off_act) begin
            rec_new.off_cnt = off_inc;
        end
        if (off_fire) begin
            // countdown expired: stop the channel
            rec_new.off_act = 1'b0;
            rec_new.off_cnt = '0;
            rec_new.off_lim = '0;
            emit            = 1'b1;
            if (timed) begin
                rec_new.blk_act = 1'b0;
                rec_new.blk_cnt = '0;
                rec_new.blk_lim = '0;
                byte_new        = byte_cur & ~bit_mask;
                emit_msg        = byte_new;
            end else begin
                emit_msg = fan_msg_reg;
            end
        end else if (timed && rec_cur.blk_act) begin
            rec_new.blk_cnt = blk_inc;
            blk_fire = (blk_inc >= blink_threshold(rec_cur.blk_lim));
            if (blk_fire) begin
                rec_new.blk_cnt = '0;
                byte_new        = byte_cur ^ bit_mask;
                emit            = 1'b1;
                emit_msg        = byte_new;
            end
        end
    end

    // a new message can only be taken if the held one can move out
    assign proceed = !(emit && pend_valid_reg && !out_free);

    always_comb begin
        arm_rec         = '0;
        arm_rec.off_lim = in_off_min;
        arm_rec.off_act = in_off_en;
        if (int'(in_ch) < TIMED_CH) begin
            arm_rec.blk_lim = in_blk_half;
            arm_rec.blk_act = in_blk_en;
        end
    end

    always_comb begin
        state_next      = state_reg;
        ch_next         = ch_reg;
        light_bits_next = light_bits_reg;
        horn_bits_next  = horn_bits_reg;
        pend_valid_next = pend_valid_reg;
        pend_msg_next   = pend_msg_reg;
        pend_ch_next    = pend_ch_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_msg_next      = m_msg_reg;
        m_ch_next       = m_ch_reg;
        m_last_next     = m_last_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = ch_reg;
        wr_data         = rec_new;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_cmd)
                        CMD_TICK: begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            ch_next    = '0;
                            state_next = ST_PROC;
                        end
                        CMD_ARM: begin
                            if (int'(in_ch) < NUM_CH) begin
                                wr_en   = 1'b1;
                                wr_addr = CH_W'(in_ch);
                                wr_data = arm_rec;
                            end
                        end
                        CMD_WRITE: begin
                            if (in_ch == WR_SEL_LIGHT) begin
                                light_bits_next = in_out_val;
                            end else if (in_ch == WR_SEL_HORN) begin
                                horn_bits_next = in_out_val;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PROC: begin
                if (proceed) begin
                    wr_en = 1'b1;
                    if (is_light) begin
                        light_bits_next = byte_new;
                    end else if (timed) begin
                        horn_bits_next = byte_new;
                    end
                    if (emit) begin
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_msg_next   = pend_msg_reg;
                            m_ch_next    = pend_ch_reg;
                            m_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_msg_next   = emit_msg;
                        pend_ch_next    = ch3;
                    end
                    if (ch_reg == CH_W'(NUM_CH - 1)) begin
                        state_next = ST_FLUSH;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = ch_reg + CH_W'(1);
                        ch_next    = ch_reg + CH_W'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_msg_next      = pend_msg_reg;
                    m_ch_next       = pend_ch_reg;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // channel memory, one write and one read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                ent_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= ent_valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ch_reg         <= '0;
            fan_msg_reg    <= 8'd0;
            light_bits_reg <= 8'd0;
            horn_bits_reg  <= 8'd0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ch_reg         <= ch_next;
            light_bits_reg <= light_bits_next;
            horn_bits_reg  <= horn_bits_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                fan_msg_reg <= cfg_wr_data;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        pend_msg_reg <= pend_msg_next;
        pend_ch_reg  <= pend_ch_next;
        m_msg_reg    <= m_msg_next;
        m_ch_reg     <= m_ch_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_msg_reg;
    assign m_tuser  = m_ch_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ----- rtl/mcobt_checker.sv -----
// ----------------------------------------------------------------------------
// mcobt_checker
// port-level checks for the multi-channel off and blink timer
// ----------------------------------------------------------------------------
module mcobt_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [mcobt_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [mcobt_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [mcobt_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                            m_tlast
);
    import mcobt_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result beat changed");

    // a tick keeps the input closed while channels are walked
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == CMD_TICK |=> !s_tready)
        else $error("input open right after a tick");

    // arm, write and unused command beats leave the input ready
    a_cmd_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser != CMD_TICK |=> s_tready)
        else $error("input closed after arm or write");

    // a tick runs at least the first read and one channel step
    a_tick_span: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == CMD_TICK |=> ##1 !s_tready)
        else $error("tick finished too early");

endmodule

bind multi_channel_off_and_blink_timer_top mcobt_checker u_mcobt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- bench/tb_multi_channel_off_and_blink_timer_top.sv -----
// ----------------------------------------------------------------------------
// tb_multi_channel_off_and_blink_timer_top
// self-checking bench for the eight-channel auto-off and blink timer
// ----------------------------------------------------------------------------
// Drives tick, arm and write beats into the input stream. Every accepted beat
// also goes through a cycle-free model of the channel timers and output bytes.
// Each tick beat in that model queues the messages it should cause, and each
// result beat is checked against the oldest queued message. Both stream sides
// idle at random. One phase holds the result side off for a long stretch, so
// the block backs up and stalls its input. The fan message register is
// rewritten between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module tb_multi_channel_off_and_blink_timer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mcobt_pkg::*;

    // command code with no function, the block must ignore it
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam int OFF_UNIT       = 60;
    localparam int BLINK_UNIT     = 30;
    localparam int RESET_CYCLES   = 5;
    // lets a silent tick walk all channels and return to idle
    localparam int SETTLE_CYCLES  = 24;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS   = 390;
    localparam int CYCLE_LIMIT    = 400000;

    // one expected result beat
    typedef struct {
        logic [7:0] msg;
        logic [2:0] src;
        logic       is_last;
    } report_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [7:0]             cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [S_TUSER_W-1:0]   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   m_tlast;

    // model copy of the channel timers and output bytes
    int unsigned off_ticks   [NUM_CH]   = '{default: 0};
    logic [9:0]  off_lim     [NUM_CH]   = '{default: '0};
    logic        off_run     [NUM_CH]   = '{default: 1'b0};
    int unsigned blink_ticks [TIMED_CH] = '{default: 0};
    logic [7:0]  blink_lim   [TIMED_CH] = '{default: '0};
    logic        blink_run   [TIMED_CH] = '{default: 1'b0};
    logic [7:0]  light_byte = 8'h00;
    logic [7:0]  horn_byte  = 8'h00;
    logic [7:0]  fan_msg    = 8'h00;

    // messages still owed by the block, oldest first
    report_t     reports_due [$];

    int          err_count   = 0;
    int unsigned cycle_count = 0;

    // idling controls: steady means no gaps on that side
    bit          tx_steady   = 1'b0;
    bit          rx_steady   = 1'b0;
    bit          rx_hold_req = 1'b0;

    multi_channel_off_and_blink_timer_top DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // small limits keep expiries reachable, the full range shows up rarely
    function automatic int pick_limit(input int top);
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 80)
            return 1;
        if (r < 92)
            return 2;
        return $urandom_range(0, top);
    endfunction

    // clear or toggle the bit a channel owns, hand back the whole byte
    function automatic logic [7:0] update_owned_bit(input int c, input bit clear_only);
        if (c < LIGHT_CHANNELS) begin
            light_byte[c] = clear_only ? 1'b0 : ~light_byte[c];
            return light_byte;
        end
        horn_byte[c - LIGHT_CHANNELS] = clear_only ? 1'b0 : ~horn_byte[c - LIGHT_CHANNELS];
        return horn_byte;
    endfunction

    // one tick: every channel in ascending order, off countdown before blink
    function automatic void predict_tick();
        report_t burst [$];
        int      due;
        for (int c = 0; c < NUM_CH; c++) begin
            if (off_run[c]) begin
                off_ticks[c]++;
                due = (off_lim[c] == 0) ? 1 : int'(off_lim[c]) * OFF_UNIT;
                if (off_ticks[c] >= due) begin
                    off_run[c]   = 1'b0;
                    off_ticks[c] = 0;
                    off_lim[c]   = '0;
                    if (c < TIMED_CH) begin
                        // an expired channel stops blinking too
                        blink_run[c]   = 1'b0;
                        blink_ticks[c] = 0;
                        blink_lim[c]   = '0;
                        burst.push_back('{update_owned_bit(c, 1'b1), 3'(c), 1'b0});
                    end else begin
                        burst.push_back('{fan_msg, 3'(c), 1'b0});
                    end
                end
            end
            if (c < TIMED_CH && blink_run[c]) begin
                blink_ticks[c]++;
                due = (blink_lim[c] == 0) ? 1 : int'(blink_lim[c]) * BLINK_UNIT;
                if (blink_ticks[c] >= due) begin
                    blink_ticks[c] = 0;
                    burst.push_back('{update_owned_bit(c, 1'b0), 3'(c), 1'b0});
                end
            end
        end
        // tlast marks the final message of the tick
        foreach (burst[i]) begin
            burst[i].is_last = (i == burst.size() - 1);
            reports_due.push_back(burst[i]);
        end
    endfunction

    // one input beat: optional gap, offer, wait for the handshake, update model
    task automatic send_beat(input logic [1:0] cmd, input logic [2:0] ch,
                             input logic [9:0] offm, input logic offen,
                             input logic [7:0] blk, input logic blken,
                             input logic [7:0] val);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, val, blken, blk, offen, offm, ch};
        do @(posedge aclk); while (!s_tready);
        case (cmd)
            CMD_ARM: begin
                if (int'(ch) < NUM_CH) begin
                    off_lim[ch]   = offm;
                    off_run[ch]   = offen;
                    off_ticks[ch] = 0;
                    // the fan has no blink timer
                    if (int'(ch) < TIMED_CH) begin
                        blink_lim[ch]   = blk;
                        blink_run[ch]   = blken;
                        blink_ticks[ch] = 0;
                    end
                end
            end
            CMD_WRITE: begin
                if (ch == WR_SEL_LIGHT)
                    light_byte = val;
                else if (ch == WR_SEL_HORN)
                    horn_byte = val;
            end
            CMD_TICK: begin
                predict_tick();
            end
            default: begin
            end
        endcase
    endtask

    // unused fields of tick, write and idle beats carry random noise
    task automatic tick_beat();
        send_beat(CMD_TICK, 3'($urandom), 10'($urandom), 1'($urandom),
                  8'($urandom), 1'($urandom), 8'($urandom));
    endtask

    task automatic arm_beat(input logic [2:0] ch, input logic [9:0] offm, input logic offen,
                            input logic [7:0] blk, input logic blken);
        send_beat(CMD_ARM, ch, offm, offen, blk, blken, 8'($urandom));
    endtask

    task automatic write_beat(input logic [2:0] sel, input logic [7:0] val);
        send_beat(CMD_WRITE, sel, 10'($urandom), 1'($urandom), 8'($urandom), 1'($urandom), val);
    endtask

    // drop valid, wait for every owed message, then let a silent tick finish
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (reports_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // register write, only called while the block is idle
    task automatic write_fan_msg(input logic [7:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        fan_msg = v;
    endtask

    // extremes of every field, ignored commands, expiry and blink corner cases
    task automatic test_directed();
        write_fan_msg(8'hFF);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        write_beat(WR_SEL_LIGHT, 8'hFF);
        write_beat(WR_SEL_HORN, 8'h00);
        // no byte behind this selector
        write_beat(3'd5, 8'h3C);
        send_beat(CMD_NONE, 3'd7, 10'h3FF, 1'b1, 8'hFF, 1'b1, 8'hFF);
        // nothing armed yet, so no message
        tick_beat();
        // zero off limit fires on the next tick and cancels the blink
        arm_beat(3'd0, 10'd0, 1'b1, 8'd255, 1'b1);
        // longest countdown, blink toggles every tick
        arm_beat(3'd5, 10'd1023, 1'b1, 8'd0, 1'b1);
        // fan ignores the blink fields
        arm_beat(3'd7, 10'd0, 1'b1, 8'd255, 1'b1);
        arm_beat(3'd6, 10'd0, 1'b0, 8'd0, 1'b1);
        tick_beat();
        tick_beat();
        arm_beat(3'd4, 10'd1, 1'b1, 8'd1, 1'b1);
        // horn bits owned by no channel keep the written value
        write_beat(WR_SEL_HORN, 8'hFF);
        tick_beat();
        arm_beat(3'd5, 10'd0, 1'b0, 8'd0, 1'b0);
        arm_beat(3'd6, 10'd0, 1'b0, 8'd0, 1'b0);
        arm_beat(3'd4, 10'd0, 1'b0, 8'd0, 1'b0);
        write_beat(WR_SEL_LIGHT, 8'h00);
        tick_beat();
        drain_block();
    endtask

    // timed channels blink on each tick, the fan reports once armed, while the result side is held off
    task automatic test_backpressure();
        write_fan_msg(8'h00);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        for (int c = 0; c < NUM_CH; c++)
            arm_beat(3'(c), 10'd0, c == NUM_CH - 1, 8'd0, 1'b1);
        // receiver stalls on its own while the sender keeps offering
        rx_hold_req = 1'b1;
        repeat (24) begin
            tick_beat();
            if ($urandom_range(0, 3) == 0)
                arm_beat(3'd7, 10'd0, 1'b1, 8'($urandom), 1'($urandom));
            if ($urandom_range(0, 5) == 0)
                write_beat(3'($urandom_range(0, 1)), 8'($urandom));
        end
        // quiet all channels again
        for (int c = 0; c < NUM_CH; c++)
            arm_beat(3'(c), 10'd0, 1'b0, 8'd0, 1'b0);
        drain_block();
    endtask

    // mostly arm and tick sequences with small limits, some writes and noise
    task automatic test_random(input int count, input logic [7:0] fan_value);
        int r;
        write_fan_msg(fan_value);
        for (int i = 0; i < count; i++) begin
            // stretches with and without idling on either side
            if (i % 50 == 0) begin
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 55)
                tick_beat();
            else if (r < 80)
                arm_beat(3'($urandom), 10'(pick_limit(1023)), 1'($urandom_range(0, 4) != 0),
                         8'(pick_limit(255)), 1'($urandom_range(0, 2) != 0));
            else if (r < 95)
                write_beat(($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'($urandom_range(0, 1)),
                           8'($urandom));
            else
                send_beat(CMD_NONE, 3'($urandom), 10'($urandom), 1'($urandom),
                          8'($urandom), 1'($urandom), 8'($urandom));
        end
        drain_block();
    endtask

    // result side: random stalls, plus the long hold-off on request
    initial begin
        int n;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (rx_steady || $urandom_range(0, 2) != 0) begin
                m_tready <= 1'b1;
            end else begin
                n = pick_gap();
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
        end
    end

    // result checker: each accepted beat against the oldest owed message
    initial begin
        report_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (reports_due.size() == 0) begin
                    $error("unexpected beat: message %0h source_channel %0d last %0b",
                           m_tdata, m_tuser, m_tlast);
                    err_count++;
                end else begin
                    want = reports_due.pop_front();
                    if (m_tdata !== want.msg) begin
                        $error("message: expected %0h actual %0h", want.msg, m_tdata);
                        err_count++;
                    end
                    if (m_tuser !== want.src) begin
                        $error("source_channel: expected %0d actual %0d", want.src, m_tuser);
                        err_count++;
                    end
                    if (m_tlast !== want.is_last) begin
                        $error("last: expected %0b actual %0b", want.is_last, m_tlast);
                        err_count++;
                    end
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_multi_channel_off_and_blink_timer_top: errors");
        $finish;
    end

    // stimulus sequence
    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 8'h00;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_backpressure();
        test_random(RANDOM_ITEMS / 2, 8'($urandom));
        test_random(RANDOM_ITEMS / 2, 8'($urandom));

        if (err_count == 0)
            $display("tb_multi_channel_off_and_blink_timer_top: clean");
        else
            $display("tb_multi_channel_off_and_blink_timer_top: errors");
        $finish;
    end

endmodule
